// ===== rtl/core/alu8_pkg.sv =====
// alu8_pkg: operation codes, flag type and decimal-adjust constants for the
// eight-bit ALU. No dependencies; used by alu8_core and the top level.
package alu8_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_DAA  = 5'd10,
    OP_CPL  = 5'd11,
    OP_SCF  = 5'd12,
    OP_CCF  = 5'd13,
    OP_RLCA = 5'd14,
    OP_RRCA = 5'd15,
    OP_RLA  = 5'd16,
    OP_RRA  = 5'd17,
    OP_RLC  = 5'd18,
    OP_RRC  = 5'd19,
    OP_RL   = 5'd20,
    OP_RR   = 5'd21,
    OP_SLA  = 5'd22,
    OP_SRA  = 5'd23,
    OP_SWAP = 5'd24,
    OP_SRL  = 5'd25,
    OP_BIT  = 5'd26,
    OP_RES  = 5'd27,
    OP_SET  = 5'd28
  } op_e;

  // packed as Z N H C, msb first
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;

endpackage

// ===== rtl/core/alu8_core.sv =====
// alu8_core: combinational datapath of the eight-bit ALU (add/sub, logic,
// DAA, rotates/shifts, bit ops). Depends on alu8_pkg.
module alu8_core (
  input  alu8_pkg::op_e    op_i,
  input  logic [7:0]       a_i,
  input  logic [7:0]       b_i,
  input  logic [2:0]       idx_i,
  input  alu8_pkg::flags_t f_i,
  output logic [7:0]       r_o,
  output alu8_pkg::flags_t f_o,
  output logic             wb_o
);

  logic       cc;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] diff9;
  logic [4:0] diff_lo;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] daa_adj;
  logic [7:0] daa_r;
  logic [7:0] bit_mask;

  // carry-in only for ADC/SBC
  assign cc = f_i.c & ((op_i == alu8_pkg::OP_ADC) | (op_i == alu8_pkg::OP_SBC));

  assign sum9    = {1'b0, a_i} + {1'b0, b_i} + {8'd0, cc};
  assign sum_lo  = {1'b0, a_i[3:0]} + {1'b0, b_i[3:0]} + {4'd0, cc};
  // bit 8 / bit 4 act as borrow out
  assign diff9   = {1'b0, a_i} - {1'b0, b_i} - {8'd0, cc};
  assign diff_lo = {1'b0, a_i[3:0]} - {1'b0, b_i[3:0]} - {4'd0, cc};

  assign daa_lo  = f_i.h | (~f_i.n & (a_i[3:0] > alu8_pkg::DaaLoLimit));
  assign daa_hi  = f_i.c | (~f_i.n & (a_i > alu8_pkg::DaaHiLimit));
  assign daa_adj = (daa_hi ? alu8_pkg::DaaHiAdj : 8'd0) | (daa_lo ? alu8_pkg::DaaLoAdj : 8'd0);
  assign daa_r   = f_i.n ? (a_i - daa_adj) : (a_i + daa_adj);

  assign bit_mask = 8'd1 << idx_i;

  always_comb begin
    r_o  = a_i;
    f_o  = f_i;
    wb_o = 1'b1;
    unique case (op_i) inside
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        r_o = sum9[7:0];
        f_o = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC, alu8_pkg::OP_CP: begin
        r_o  = diff9[7:0];
        f_o  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
        wb_o = (op_i != alu8_pkg::OP_CP);
      end
      alu8_pkg::OP_AND: begin
        r_o = a_i & b_i;
        f_o = '{z: ((a_i & b_i) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      alu8_pkg::OP_XOR: begin
        r_o = a_i ^ b_i;
        f_o = '{z: ((a_i ^ b_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8_pkg::OP_OR: begin
        r_o = a_i | b_i;
        f_o = '{z: ((a_i | b_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8_pkg::OP_INC: begin
        r_o = a_i + 8'd1;
        f_o = '{z: (a_i == 8'hff), n: 1'b0, h: (a_i[3:0] == 4'hf), c: f_i.c};
      end
      alu8_pkg::OP_DEC: begin
        r_o = a_i - 8'd1;
        f_o = '{z: (a_i == 8'h01), n: 1'b1, h: (a_i[3:0] == 4'h0), c: f_i.c};
      end
      alu8_pkg::OP_DAA: begin
        r_o = daa_r;
        f_o = '{z: (daa_r == 8'd0), n: f_i.n, h: 1'b0, c: daa_hi};
      end
      alu8_pkg::OP_CPL: begin
        r_o = ~a_i;
        f_o = '{z: f_i.z, n: 1'b1, h: 1'b1, c: f_i.c};
      end
      alu8_pkg::OP_SCF: begin
        wb_o = 1'b0;
        f_o  = '{z: f_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      alu8_pkg::OP_CCF: begin
        wb_o = 1'b0;
        f_o  = '{z: f_i.z, n: 1'b0, h: 1'b0, c: ~f_i.c};
      end
      // accumulator rotates always clear Z; prefixed ones test the result
      alu8_pkg::OP_RLCA, alu8_pkg::OP_RLC: begin
        r_o = {a_i[6:0], a_i[7]};
        f_o = '{z: (op_i == alu8_pkg::OP_RLC) & (a_i == 8'd0), n: 1'b0, h: 1'b0, c: a_i[7]};
      end
      alu8_pkg::OP_RRCA, alu8_pkg::OP_RRC: begin
        r_o = {a_i[0], a_i[7:1]};
        f_o = '{z: (op_i == alu8_pkg::OP_RRC) & (a_i == 8'd0), n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      alu8_pkg::OP_RLA, alu8_pkg::OP_RL: begin
        r_o = {a_i[6:0], f_i.c};
        f_o = '{z: (op_i == alu8_pkg::OP_RL) & ({a_i[6:0], f_i.c} == 8'd0),
                n: 1'b0, h: 1'b0, c: a_i[7]};
      end
      alu8_pkg::OP_RRA, alu8_pkg::OP_RR: begin
        r_o = {f_i.c, a_i[7:1]};
        f_o = '{z: (op_i == alu8_pkg::OP_RR) & ({f_i.c, a_i[7:1]} == 8'd0),
                n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      alu8_pkg::OP_SLA: begin
        r_o = {a_i[6:0], 1'b0};
        f_o = '{z: (a_i[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: a_i[7]};
      end
      alu8_pkg::OP_SRA: begin
        r_o = {a_i[7], a_i[7:1]};
        f_o = '{z: (a_i[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      alu8_pkg::OP_SWAP: begin
        r_o = {a_i[3:0], a_i[7:4]};
        f_o = '{z: (a_i == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8_pkg::OP_SRL: begin
        r_o = {1'b0, a_i[7:1]};
        f_o = '{z: (a_i[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a_i[0]};
      end
      alu8_pkg::OP_BIT: begin
        wb_o = 1'b0;
        f_o  = '{z: ~a_i[idx_i], n: 1'b0, h: 1'b1, c: f_i.c};
      end
      alu8_pkg::OP_RES: r_o = a_i & ~bit_mask;
      alu8_pkg::OP_SET: r_o = a_i | bit_mask;
      default: wb_o = 1'b0;  // unassigned codes pass A through, no write
    endcase
  end

endmodule

// ===== rtl/core/eight_bit_alu_with_flags.sv =====
// eight_bit_alu_with_flags: top level, input register, alu8_core and result
// register with valid/ready handshakes. Depends on alu8_pkg and alu8_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation word: opcode,
//   operand A, operand B, bit index and the incoming Z/N/H/C flags.
//   Output channel (out_valid_o/out_ready_i) returns one word per input:
//   result byte, new flags and the write-back mark.
//   Path: an accepted word goes into the input register, then through the ALU
//   logic into the result register, which presents it on the output.
//   Throughput: one word per cycle while out_ready_i stays high; the ALU logic
//   between the two registers is 9-bit add and subtract, DAA, shifts and selection.
//   Stall: when the receiver holds out_ready_i low, the result register
//   keeps its word and the input register keeps one more; in_ready_o drops
//   only when both are full. Words are never dropped or duplicated.
//   Reset: rst_ni clears both valid bits; no words are in flight afterward.
module eight_bit_alu_with_flags (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] operation_i,
  input  logic [7:0] operand_a_i,
  input  logic [7:0] operand_b_i,
  input  logic [2:0] bit_index_i,
  input  logic [3:0] flags_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] result_o,
  output logic [3:0] flags_out_o,
  output logic       write_back_o
);

  logic             s1_valid_q;
  alu8_pkg::op_e    s1_op_q;
  logic [7:0]       s1_a_q;
  logic [7:0]       s1_b_q;
  logic [2:0]       s1_idx_q;
  alu8_pkg::flags_t s1_flags_q;

  logic             out_valid_q;
  logic [7:0]       out_result_q;
  alu8_pkg::flags_t out_flags_q;
  logic             out_wb_q;

  logic             out_ready_int;
  logic             s1_ready;
  logic [7:0]       result_d;
  alu8_pkg::flags_t flags_d;
  logic             wb_d;

  assign out_ready_int = ~out_valid_q | out_ready_i;
  assign s1_ready      = ~s1_valid_q | out_ready_int;
  assign in_ready_o    = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_op_q    <= alu8_pkg::op_e'(operation_i);
      s1_a_q     <= operand_a_i;
      s1_b_q     <= operand_b_i;
      s1_idx_q   <= bit_index_i;
      s1_flags_q <= alu8_pkg::flags_t'(flags_in_i);
    end
  end

  alu8_core u_core (
    .op_i  (s1_op_q),
    .a_i   (s1_a_q),
    .b_i   (s1_b_q),
    .idx_i (s1_idx_q),
    .f_i   (s1_flags_q),
    .r_o   (result_d),
    .f_o   (flags_d),
    .wb_o  (wb_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready_int) begin
      out_result_q <= result_d;
      out_flags_q  <= flags_d;
      out_wb_q     <= wb_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = out_result_q;
  assign flags_out_o  = out_flags_q;
  assign write_back_o = out_wb_q;

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // accepted word is captured in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted word lost");

  // a stalled pipeline keeps its queued word
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_a_q)))
    else $error("queued word dropped during stall");

  // compare and bit test never write back
  a_no_wb_cp_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_op_q == alu8_pkg::OP_CP || s1_op_q == alu8_pkg::OP_BIT)) |-> !wb_d)
    else $error("write-back set for compare or bit test");

  // word in the input register moves to the output when the output is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_ready_int) |=> out_valid_q)
    else $error("result not registered");

endmodule
